// ===== rtl/edtc_pkg.sv =====
// ----------------------------------------------------------------------------
// edtc_pkg - shared types and constants for the echo distance to tone block
// Command codes, the stage control struct and the fixed-point constants
// for the tick to centimeter and volume scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edtc_pkg;

   // Default widths of the capture timer and the overflow counter
   localparam int TIMER_BITS_DEF    = 16;
   localparam int OVERFLOW_BITS_DEF = 8;

   // Payload widths fixed by the word format
   localparam int CMD_BITS     = 2;
   localparam int CAPTURE_BITS = 16;
   localparam int LIGHT_BITS   = 10;
   localparam int STORE_BITS   = 8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CAPTURE  = 2'd0,
      CMD_OVERFLOW = 2'd1,
      CMD_UPDATE   = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // Control handed from the input register to the working modules
   typedef struct packed {
      logic    fire;
      cmd_type cmd;
      logic    echo_high;
      logic    continuous_mode;
   } edtc_op_type;

   // Distance: cm = floor(ticks * 500 / 58309), saturated at 255.
   // Saturation starts at ceil(256 * 116618 / 1000) ticks; below that the
   // tick count fits 15 bits and a reciprocal multiply is exact.
   localparam int CM_SAT_TICKS  = (256 * 116618 + 999) / 1000;
   localparam int CM_TICK_BITS  = 15;
   localparam int CM_RECIP_BITS = 25;
   localparam int CM_SHIFT      = 31;
   localparam int CM_PROD_BITS  = CM_TICK_BITS + CM_RECIP_BITS;
   localparam logic [CM_RECIP_BITS-1:0] CM_RECIP =
      CM_RECIP_BITS'(((64'd1 << CM_SHIFT) * 64'd500 + 64'd58308) / 64'd58309);

   // Tone mapping
   localparam int PERIOD_BITS      = 7;
   localparam int PERIOD_MIN       = 59;
   localparam int PERIOD_MAX       = 119;
   localparam int PERIOD_RESET     = 71;
   localparam int COMPARE_RESET    = 35;
   localparam int TONE_STEP_LIMIT  = 72;   // cm / 9 reaches 8 here
   localparam int TONE_IDX_MUL     = 57;   // cm * 57 >> 9 == cm / 9 for cm < 72
   localparam int TONE_IDX_SHIFT   = 9;
   localparam int TONE_IDX_PROD    = 14;
   localparam logic [PERIOD_BITS-1:0] TONE_TABLE [8] =
      '{7'd59, 7'd62, 7'd70, 7'd79, 7'd89, 7'd94, 7'd106, 7'd119};

   // Volume: compare = floor(period * light / 2000) via light * ceil(2^28 / 2000)
   localparam int VOL_FULL_LEVEL  = 1000;
   localparam int VOL_SHIFT       = 28;
   localparam int VOL_RECIP_BITS  = 18;
   localparam int VOL_SCALED_BITS = LIGHT_BITS + VOL_RECIP_BITS;
   localparam logic [VOL_RECIP_BITS-1:0] VOL_RECIP =
      VOL_RECIP_BITS'(((64'd1 << VOL_SHIFT) + 64'd1999) / 64'd2000);

endpackage

// ===== rtl/edtc_if.sv =====
// ----------------------------------------------------------------------------
// edtc_if - request and response channels of the echo distance to tone block
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface edtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] capture_time;
   logic        echo_high;
   logic        continuous_mode;
   logic [9:0]  light_level;

   modport source (output valid, cmd, capture_time, echo_high, continuous_mode,
                   light_level, input ready);
   modport sink   (input valid, cmd, capture_time, echo_high, continuous_mode,
                   light_level, output ready);
endinterface

interface edtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tone_period;
   logic [7:0] tone_compare;
   logic [7:0] distance_cm;
   logic       measure_done;

   modport source (output valid, tone_period, tone_compare, distance_cm,
                   measure_done, input ready);
   modport sink   (input valid, tone_period, tone_compare, distance_cm,
                   measure_done, output ready);
endinterface

// ===== rtl/edtc_meas.sv =====
// ----------------------------------------------------------------------------
// edtc_meas - echo pulse timing and distance conversion
// Holds the start time and overflow count, and on a falling edge turns the
// pulse width into whole centimeters, saturated at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edtc_meas #(
   parameter int TIMER_BITS    = edtc_pkg::TIMER_BITS_DEF,
   parameter int OVERFLOW_BITS = edtc_pkg::OVERFLOW_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  edtc_pkg::edtc_op_type         op,
   input  logic [TIMER_BITS-1:0]         capture,
   output logic [edtc_pkg::STORE_BITS-1:0] distance,
   output logic [edtc_pkg::STORE_BITS-1:0] distance_next
);
   import edtc_pkg::*;

   localparam int TW   = TIMER_BITS + OVERFLOW_BITS;
   localparam int WIDE = (TW > 16) ? TW : 16;

   logic [TIMER_BITS-1:0]    start_ff, start_in;
   logic [OVERFLOW_BITS-1:0] ovf_ff, ovf_in;
   logic [STORE_BITS-1:0]    dist_ff, dist_in;

   logic [TW-1:0]            total;
   logic [TW-1:0]            ticks_raw;
   logic [WIDE-1:0]          ticks;
   logic                     sat;
   logic [CM_PROD_BITS-1:0]  cm_prod;
   logic [STORE_BITS-1:0]    cm;

   // Pulse width in ticks, clamped at zero
   assign total     = {ovf_ff, capture};
   assign ticks_raw = total - TW'(start_ff);
   assign ticks     = (total < TW'(start_ff)) ? '0 : WIDE'(ticks_raw);
   assign sat       = ticks >= WIDE'(CM_SAT_TICKS);

   // Reciprocal multiply, exact below the saturation point
   assign cm_prod = CM_PROD_BITS'(ticks[CM_TICK_BITS-1:0]) * CM_PROD_BITS'(CM_RECIP);
   assign cm      = cm_prod[CM_SHIFT +: STORE_BITS];

   // Next state
   always_comb begin
      start_in = start_ff;
      ovf_in   = ovf_ff;
      dist_in  = dist_ff;
      if (op.fire) begin
         unique case (op.cmd)
            CMD_CAPTURE: begin
               ovf_in = '0;
               if (op.echo_high) begin
                  start_in = capture;
               end else begin
                  dist_in = sat ? '1 : cm;
               end
            end
            CMD_OVERFLOW: begin
               if (op.echo_high && (ovf_ff != '1)) begin
                  ovf_in = ovf_ff + 1'b1;
               end
            end
            CMD_UPDATE, CMD_UNUSED: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         ovf_ff   <= '0;
         dist_ff  <= '0;
      end else begin
         start_ff <= start_in;
         ovf_ff   <= ovf_in;
         dist_ff  <= dist_in;
      end
   end

   assign distance      = dist_ff;
   assign distance_next = dist_in;

`ifndef SYNTH
   // Any edge restarts the overflow count
   a_edge_clears_ovf: assert property (@(posedge clock) disable iff (reset)
      op.fire && (op.cmd == CMD_CAPTURE) |=> ovf_ff == '0)
      else $error("overflow count not cleared by capture edge");

   // Distance only moves when a word is processed
   a_dist_quiet: assert property (@(posedge clock) disable iff (reset)
      !op.fire |=> $stable(dist_ff))
      else $error("distance changed without a word");

   // Start time only moves on a rising edge
   a_start_hold: assert property (@(posedge clock) disable iff (reset)
      !(op.fire && (op.cmd == CMD_CAPTURE) && op.echo_high) |=> $stable(start_ff))
      else $error("start time changed without a rising edge");
`endif

endmodule

// ===== rtl/edtc_tone.sv =====
// ----------------------------------------------------------------------------
// edtc_tone - tone period and volume compare mapping
// Maps the stored distance to a tone period, continuously or through the
// step table, and scales it by the light level into the duty compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edtc_tone (
   input  logic                                 clock,
   input  logic                                 reset,
   input  edtc_pkg::edtc_op_type                op,
   input  logic [edtc_pkg::STORE_BITS-1:0]      distance,
   input  logic [edtc_pkg::VOL_SCALED_BITS-1:0] light_scaled,
   input  logic                                 light_full,
   output logic [edtc_pkg::STORE_BITS-1:0]      period_next,
   output logic [edtc_pkg::STORE_BITS-1:0]      compare_next
);
   import edtc_pkg::*;

   localparam int VOL_PROD_BITS = PERIOD_BITS + VOL_SCALED_BITS;

   logic [STORE_BITS-1:0]    period_ff, period_in;
   logic [STORE_BITS-1:0]    compare_ff, compare_in;

   logic [STORE_BITS:0]      cont_sum;
   logic [PERIOD_BITS-1:0]   cont_period;
   logic [TONE_IDX_PROD-1:0] idx_prod;
   logic [2:0]               tone_idx;
   logic [PERIOD_BITS-1:0]   disc_period;
   logic [PERIOD_BITS-1:0]   period;
   logic [VOL_PROD_BITS-1:0] vol_prod;
   logic [PERIOD_BITS-1:0]   compare;

   // Continuous mapping: distance + 59, capped
   assign cont_sum    = (STORE_BITS + 1)'(distance) + (STORE_BITS + 1)'(PERIOD_MIN);
   assign cont_period = (cont_sum > (STORE_BITS + 1)'(PERIOD_MAX)) ?
                        PERIOD_BITS'(PERIOD_MAX) : cont_sum[PERIOD_BITS-1:0];

   // Discrete mapping: table step of distance / 9
   assign idx_prod    = TONE_IDX_PROD'(distance) * TONE_IDX_PROD'(TONE_IDX_MUL);
   assign tone_idx    = idx_prod[TONE_IDX_SHIFT +: 3];
   assign disc_period = (distance >= STORE_BITS'(TONE_STEP_LIMIT)) ?
                        PERIOD_BITS'(PERIOD_MAX) : TONE_TABLE[tone_idx];

   assign period = op.continuous_mode ? cont_period : disc_period;

   // Volume scaling
   assign vol_prod = VOL_PROD_BITS'(period) * VOL_PROD_BITS'(light_scaled);
   assign compare  = light_full ? (period >> 1) : vol_prod[VOL_SHIFT +: PERIOD_BITS];

   always_comb begin
      period_in  = period_ff;
      compare_in = compare_ff;
      if (op.fire && (op.cmd == CMD_UPDATE)) begin
         period_in  = STORE_BITS'(period);
         compare_in = STORE_BITS'(compare);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= STORE_BITS'(PERIOD_RESET);
         compare_ff <= STORE_BITS'(COMPARE_RESET);
      end else begin
         period_ff  <= period_in;
         compare_ff <= compare_in;
      end
   end

   assign period_next  = period_in;
   assign compare_next = compare_in;

`ifndef SYNTH
   a_period_range: assert property (@(posedge clock) disable iff (reset)
      period_ff >= STORE_BITS'(PERIOD_MIN) && period_ff <= STORE_BITS'(PERIOD_MAX))
      else $error("tone period out of range");

   // Duty never exceeds half the period
   a_compare_half: assert property (@(posedge clock) disable iff (reset)
      compare_ff <= (period_ff >> 1))
      else $error("tone compare above half period");

   a_tone_quiet: assert property (@(posedge clock) disable iff (reset)
      !op.fire |=> $stable(period_ff) && $stable(compare_ff))
      else $error("tone stores changed without a word");
`endif

endmodule

// ===== rtl/echo_distance_to_tone_controller.sv =====
// ----------------------------------------------------------------------------
// echo_distance_to_tone_controller - ultrasonic echo distance to tone
// Request words (req_chan) carry a capture edge, an overflow tick or a tone
// update; every request word yields exactly one response word (rsp_chan)
// holding the current tone period, duty compare and distance, with
// measure_done set when the word was a falling-edge capture.
// Both channels are valid/ready; a word moves when both are high.
// Latency: a request accepted into the input register is processed once the
// response register is free, and its response is then registered there.
// Throughput: one word per cycle while the receiver does not stall; the input
// register and the response register form a two-entry pipe, so a new word
// is taken while a response waits. When the receiver stalls, the response
// holds and the pipe fills; ready drops only once both registers are full.
// Reset (synchronous, active high) empties the pipe and returns the stores
// to period 71, compare 35, distance 0, with start time and overflow count 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_distance_to_tone_controller #(
   parameter int TIMER_BITS    = edtc_pkg::TIMER_BITS_DEF,
   parameter int OVERFLOW_BITS = edtc_pkg::OVERFLOW_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   edtc_req_if.sink          req_chan,
   edtc_rsp_if.source        rsp_chan
);
   import edtc_pkg::*;

   localparam int CAP_BITS = (TIMER_BITS < CAPTURE_BITS) ? TIMER_BITS : CAPTURE_BITS;

   // Input register
   logic                       s1_valid_ff, s1_valid_in;
   cmd_type                    cmd_ff;
   logic [TIMER_BITS-1:0]      cap_ff;
   logic                       echo_ff;
   logic                       cont_ff;
   logic [VOL_SCALED_BITS-1:0] light_scaled_ff;
   logic                       light_full_ff;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STORE_BITS-1:0]      rsp_period_ff;
   logic [STORE_BITS-1:0]      rsp_compare_ff;
   logic [STORE_BITS-1:0]      rsp_dist_ff;
   logic                       rsp_done_ff;

   logic                       accept;
   logic                       out_free;
   logic                       s1_adv;
   edtc_op_type                op;
   logic [STORE_BITS-1:0]      distance;
   logic [STORE_BITS-1:0]      distance_next;
   logic [STORE_BITS-1:0]      period_next;
   logic [STORE_BITS-1:0]      compare_next;

   // Handshake and pipe control
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request word; light is prescaled for the volume multiply
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff          <= cmd_type'(req_chan.cmd);
         cap_ff          <= TIMER_BITS'(req_chan.capture_time[CAP_BITS-1:0]);
         echo_ff         <= req_chan.echo_high;
         cont_ff         <= req_chan.continuous_mode;
         light_scaled_ff <= VOL_SCALED_BITS'(req_chan.light_level) *
                            VOL_SCALED_BITS'(VOL_RECIP);
         light_full_ff   <= req_chan.light_level >= LIGHT_BITS'(VOL_FULL_LEVEL);
      end
   end

   assign op.fire            = s1_adv;
   assign op.cmd             = cmd_ff;
   assign op.echo_high       = echo_ff;
   assign op.continuous_mode = cont_ff;

   edtc_meas #(
      .TIMER_BITS    (TIMER_BITS),
      .OVERFLOW_BITS (OVERFLOW_BITS)
   ) u_meas (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .capture       (cap_ff),
      .distance      (distance),
      .distance_next (distance_next)
   );

   edtc_tone u_tone (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .distance     (distance),
      .light_scaled (light_scaled_ff),
      .light_full   (light_full_ff),
      .period_next  (period_next),
      .compare_next (compare_next)
   );

   // Response word
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_period_ff  <= period_next;
         rsp_compare_ff <= compare_next;
         rsp_dist_ff    <= distance_next;
         rsp_done_ff    <= (cmd_ff == CMD_CAPTURE) && !echo_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tone_period  = rsp_period_ff;
   assign rsp_chan.tone_compare = rsp_compare_ff;
   assign rsp_chan.distance_cm  = rsp_dist_ff;
   assign rsp_chan.measure_done = rsp_done_ff;

`ifndef SYNTH
   // Back pressure only when both registers hold a word
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipe");

   // A waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !s1_adv)
      else $error("pending response overwritten");

   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("processed word produced no response");
`endif

endmodule

// ===== verif/edtc_checker.sv =====
// ----------------------------------------------------------------------------
// edtc_checker - response checker for the echo distance to tone block
// Watches both channels. Every request word taken by the block updates a
// local copy of the pulse timer, distance and tone stores, and queues the
// response word that should follow. Each response word taken from the block
// is checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edtc_checker (
   input  logic clock,
   input  logic reset,
   edtc_req_if  req,
   edtc_rsp_if  rsp,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   import edtc_pkg::*;

   typedef struct packed {
      logic [7:0] period;
      logic [7:0] compare;
      logic [7:0] distance;
      logic       done;
   } tone_word_type;

   // Timer ticks per 1000 cm of echo distance (58.309 us/cm at 2 MHz, doubled)
   localparam longint unsigned TICKS_PER_KCM = 116618;
   localparam int PITCH_LOW    = 59;
   localparam int PITCH_HIGH   = 119;
   localparam int CM_PER_STEP  = 9;
   localparam int LIGHT_FULL   = 1000;
   localparam int VOLUME_DIV   = 2000;
   localparam logic [7:0] WRAP_MAX = 8'hFF;
   localparam logic [7:0] PITCH_STEPS [8] =
      '{8'd59, 8'd62, 8'd70, 8'd79, 8'd89, 8'd94, 8'd106, 8'd119};

   // Local copy of the block's state
   logic [15:0] pulse_start;
   logic [7:0]  wrap_count;
   logic [7:0]  dist_cm;
   logic [7:0]  period_q;
   logic [7:0]  compare_q;

   tone_word_type   expected_tones [$];
   tone_word_type   want;
   longint unsigned total;
   longint unsigned ticks;
   logic [7:0]      pitch;
   logic            done;

   always @(posedge clock) begin
      if (reset) begin
         pulse_start = '0;
         wrap_count  = '0;
         dist_cm     = '0;
         period_q    = 8'd71;
         compare_q   = 8'd35;
         expected_tones.delete();
      end else begin
         // response side first: a response never belongs to a word taken now
         if (rsp.valid && rsp.ready) begin
            if (expected_tones.size() == 0) begin
               $error("unexpected response word: period %0d compare %0d distance %0d done %0b",
                      rsp.tone_period, rsp.tone_compare, rsp.distance_cm, rsp.measure_done);
               fail_count++;
            end else begin
               want = expected_tones.pop_front();
               checked++;
               if (rsp.tone_period !== want.period) begin
                  $error("tone_period: expected %0d, got %0d", want.period, rsp.tone_period);
                  fail_count++;
               end
               if (rsp.tone_compare !== want.compare) begin
                  $error("tone_compare: expected %0d, got %0d", want.compare, rsp.tone_compare);
                  fail_count++;
               end
               if (rsp.distance_cm !== want.distance) begin
                  $error("distance_cm: expected %0d, got %0d", want.distance, rsp.distance_cm);
                  fail_count++;
               end
               if (rsp.measure_done !== want.done) begin
                  $error("measure_done: expected %0b, got %0b", want.done, rsp.measure_done);
                  fail_count++;
               end
            end
         end

         // request side: advance the local state, queue the response
         if (req.valid && req.ready) begin
            done = 1'b0;
            case (cmd_type'(req.cmd))
               CMD_CAPTURE: begin
                  if (req.echo_high) begin
                     pulse_start = req.capture_time;
                     wrap_count  = '0;
                  end else begin
                     total   = (longint'(wrap_count) << 16) + req.capture_time;
                     ticks   = (total >= pulse_start) ? total - pulse_start : 0;
                     ticks   = ticks * 1000 / TICKS_PER_KCM;
                     dist_cm = (ticks > 255) ? 8'd255 : ticks[7:0];
                     wrap_count = '0;
                     done       = 1'b1;
                  end
               end
               CMD_OVERFLOW: begin
                  // counts only while the echo is high, sticks at all ones
                  if (req.echo_high && wrap_count != WRAP_MAX)
                     wrap_count++;
               end
               CMD_UPDATE: begin
                  if (req.continuous_mode)
                     pitch = 8'((dist_cm > PITCH_HIGH - PITCH_LOW) ? PITCH_HIGH :
                                dist_cm + PITCH_LOW);
                  else if (dist_cm / CM_PER_STEP >= 8)
                     pitch = 8'(PITCH_HIGH);
                  else
                     pitch = PITCH_STEPS[3'(dist_cm / CM_PER_STEP)];
                  period_q  = pitch;
                  compare_q = 8'((req.light_level >= LIGHT_FULL) ? pitch >> 1 :
                                 (pitch * req.light_level) / VOLUME_DIV);
               end
               default: ;  // unused code leaves the state alone
            endcase
            expected_tones.push_back('{period_q, compare_q, dist_cm, done});
         end
      end
      pending = expected_tones.size();
   end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - top level test of echo_distance_to_tone_controller
// Drives request words: a short directed set (table edges, clamps, saturation,
// unused command), then random echo measurements with tone updates mixed with
// noise words, under three sender/receiver stall mixes. The checker beside
// the block predicts and compares every response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import edtc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 410;

   logic clock = 1'b0;
   logic reset;

   int gap_pct;
   int stall_pct;
   int cycle_count;
   int words_sent;
   int pulses_sent;
   int updates_sent;
   int fail_count;
   int pending;
   int checked;

   edtc_req_if req_chan ();
   edtc_rsp_if rsp_chan ();

   echo_distance_to_tone_controller u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   edtc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[echo_distance_to_tone_controller] ERROR");
         $finish;
      end
   end

   // Light level with extra weight around the full-volume threshold
   function automatic logic [9:0] pick_light();
      if ($urandom_range(3) == 0)
         return 10'($urandom_range(990, 1023));
      return 10'($urandom_range(0, 1023));
   endfunction

   // Smallest tick count that measures as cm
   function automatic int unsigned ticks_for_cm(input int unsigned cm);
      return (cm * 116618 + 999) / 1000;
   endfunction

   // One request word, with random idle cycles in front
   task automatic send_word(input cmd_type op, input logic [15:0] cap, input logic echo,
                            input logic cont, input logic [9:0] light);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.cmd             <= op;
      req_chan.capture_time    <= cap;
      req_chan.echo_high       <= echo;
      req_chan.continuous_mode <= cont;
      req_chan.light_level     <= light;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      if (op == CMD_UPDATE) updates_sent++;
      if (op == CMD_CAPTURE && !echo) pulses_sent++;
   endtask

   task automatic send_update(input logic cont, input logic [9:0] light);
      send_word(CMD_UPDATE, 16'($urandom), 1'($urandom_range(1)), cont, light);
   endtask

   // Rising edge at t0, one overflow word per timer wrap, falling edge
   task automatic measure_pulse(input logic [15:0] t0, input int unsigned ticks,
                                input int unsigned extra_wraps);
      logic [15:0] t1;
      int unsigned wraps;
      t1    = t0 + ticks[15:0];
      wraps = ((t0 + ticks) >> 16) + extra_wraps;
      send_word(CMD_CAPTURE, t0, 1'b1, 1'($urandom_range(1)), pick_light());
      for (int i = 0; i < wraps; i++) begin
         // stray tick with echo low: ignored
         if ($urandom_range(9) == 0)
            send_word(CMD_OVERFLOW, 16'($urandom), 1'b0, 1'($urandom_range(1)), pick_light());
         send_word(CMD_OVERFLOW, 16'($urandom), 1'b1, 1'($urandom_range(1)), pick_light());
      end
      send_word(CMD_CAPTURE, t1, 1'b0, 1'($urandom_range(1)), pick_light());
   endtask

   // Random traffic: mostly well-formed measurements, the rest noise
   task automatic run_phase(input int gap, input int stall, input bit with_burst);
      int first_word;
      int unsigned ticks;
      gap_pct    = gap;
      stall_pct  = stall;
      first_word = words_sent;
      // overflow count held at all ones, then a short pulse on top of it
      if (with_burst)
         measure_pulse(16'($urandom_range(0, 60000)), $urandom_range(0, 5000), 256);
      while (words_sent - first_word < PHASE_WORDS) begin
         if ($urandom_range(99) < 70) begin
            ticks = $urandom_range(1) ? $urandom_range(0, 9000) : $urandom_range(0, 31000);
            measure_pulse(16'($urandom), ticks,
                          ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
            if ($urandom_range(4) != 0) send_update(1'($urandom_range(1)), pick_light());
            if ($urandom_range(3) == 0) send_update(1'($urandom_range(1)), pick_light());
         end else begin
            send_word(cmd_type'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 10'($urandom_range(0, 1023)));
         end
      end
   endtask

   initial begin
      gap_pct   = 23;
      stall_pct = 70;
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.cmd             <= CMD_CAPTURE;
      req_chan.capture_time    <= '0;
      req_chan.echo_high       <= 1'b0;
      req_chan.continuous_mode <= 1'b0;
      req_chan.light_level     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset stores, volume threshold, clamps, table edges
      send_update(1'b0, 10'd0);
      send_update(1'b1, 10'h3FF);
      send_word(CMD_CAPTURE, 16'hFFFF, 1'b0, 1'b0, 10'd0);   // falling edge, no rising edge
      send_update(1'b1, 10'd999);
      send_update(1'b0, 10'd1000);
      send_word(CMD_CAPTURE, 16'hFFFF, 1'b1, 1'b1, 10'h3FF); // end before start: clamp to 0
      send_word(CMD_CAPTURE, 16'h0000, 1'b0, 1'b0, 10'd0);
      send_update(1'b1, 10'd500);
      send_word(CMD_OVERFLOW, 16'h0000, 1'b0, 1'b0, 10'd0);  // tick while echo low
      send_word(CMD_UNUSED, 16'hFFFF, 1'b1, 1'b1, 10'h3FF);
      measure_pulse(16'd1000, ticks_for_cm(71), 0);          // last table step
      send_update(1'b0, 10'd1023);
      measure_pulse(16'hF000, ticks_for_cm(72), 0);          // past the table, one wrap
      send_update(1'b0, 10'd1);
      measure_pulse(16'h0000, ticks_for_cm(60), 0);          // continuous top edge
      send_update(1'b1, 10'd1000);
      measure_pulse(16'd500, 100, 2);                        // distance saturates
      send_update(1'b1, 10'd2);

      run_phase(23, 70, 1'b0);
      run_phase(70, 23, 1'b0);
      run_phase(0, 0, 1'b1);
      req_chan.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d request words: %0d echo measurements, %0d tone updates.",
               words_sent, pulses_sent, updates_sent);
      $display("Compared %0d response words over three stall mixes.", checked);
      if (fail_count == 0)
         $display("[echo_distance_to_tone_controller] OK");
      else
         $display("[echo_distance_to_tone_controller] ERROR");
      $finish;
   end

endmodule
